@@ sv/url_percent_decoder_macros.svh @@
// Assertion macros for the URL percent decoder.
// Included by files that carry concurrent checks; assumes clk and rst in scope.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define URLPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define URLPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define URLPD_ASSERT(lbl, prop, msg)
`define URLPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/urlpd_pkg.sv @@
// Shared types and constants for the URL percent decoder.
// No dependencies; used by the front end, queue, back end and top level.
package urlpd_pkg;

  localparam int URLPD_QUEUE_DEPTH = 4;

  // Escape tracking phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  // Decoded output of one encoded byte: up to three bytes, oldest in data[0].
  typedef struct packed {
    logic            last;
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
  } entry_t;

  typedef struct packed {
    logic [1:0] phase;
  } front_status_t;

endpackage

@@ sv/urlpd_if.sv @@
// Stream channel interfaces for the URL percent decoder.
// Depends on nothing; one interface for encoded input, one for decoded output.
interface urlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urlpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ sv/urlpd_front.sv @@
// Front end: accepts encoded bytes, tracks escape phase, builds queue entries.
// Depends on urlpd_pkg and urlpd_in_if.
module urlpd_front import urlpd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  urlpd_in_if.sink      in_ch,
  input  logic          q_ready,
  output logic          push,
  output entry_t        push_entry,
  output front_status_t status
);

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF  = 8'h66;
  localparam logic [7:0] HEX_TEN = 8'd10;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_LA) begin
      v = c - CH_LA + HEX_TEN;
    end else if (c >= CH_UA) begin
      v = c - CH_UA + HEX_TEN;
    end else begin
      v = c - CH_0;
    end
    return v[3:0];
  endfunction

  function automatic entry_t push_byte(entry_t e, logic [7:0] x);
    entry_t r;
    r = e;
    case (e.cnt)
      2'd0: begin
        r.data[0] = x;
      end
      2'd1: begin
        r.data[1] = x;
      end
      default: begin
        r.data[2] = x;
      end
    endcase
    r.cnt = e.cnt + 2'd1;
    return r;
  endfunction

  logic [1:0] phase, phase_next;
  logic [7:0] held, held_next;
  logic       accept;
  entry_t     e;
  logic       b_hex;
  logic       run_idle;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign b_hex       = is_hex(in_ch.in_byte);

  always_comb begin
    e          = '0;
    phase_next = phase;
    held_next  = held;
    run_idle   = 1'b1;
    case (phase)
      PH_PCT: begin
        if (b_hex) begin
          held_next  = in_ch.in_byte;
          phase_next = PH_DIGIT;
          run_idle   = 1'b0;
        end else begin
          e = push_byte(e, CH_PCT);
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          e          = push_byte(e, {hex_value(held), hex_value(in_ch.in_byte)});
          phase_next = PH_IDLE;
          run_idle   = 1'b0;
        end else begin
          e = push_byte(e, CH_PCT);
          e = push_byte(e, held);
        end
      end
      default: begin
      end
    endcase
    if (run_idle) begin
      if (in_ch.in_byte == CH_PCT) begin
        phase_next = PH_PCT;
      end else begin
        phase_next = PH_IDLE;
        e          = push_byte(e, in_ch.in_byte);
      end
    end
    // Flush a pending escape as literals at end of message.
    if (in_ch.in_last) begin
      if (phase_next == PH_PCT) begin
        e = push_byte(e, CH_PCT);
      end else if (phase_next == PH_DIGIT) begin
        e = push_byte(e, CH_PCT);
        e = push_byte(e, held_next);
      end
      e.last     = 1'b1;
      phase_next = PH_IDLE;
      held_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  assign push         = accept && (e.cnt != 2'd0);
  assign push_entry   = e;
  assign status.phase = phase;

endmodule

@@ sv/urlpd_queue.sv @@
// Short entry queue between front and back ends.
// Depends on urlpd_pkg.
module urlpd_queue import urlpd_pkg::*; #(
  parameter int Depth = URLPD_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   ready,
  input  logic   pop,
  output entry_t head,
  output logic   head_valid
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  entry_t        mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign ready      = (count != CW'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ sv/urlpd_back.sv @@
// Back end: drains queue entries one byte per cycle, while the output is not stalled, into the output register.
// Depends on urlpd_pkg and urlpd_out_if.
module urlpd_back import urlpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        head_valid,
  output logic        pop,
  urlpd_out_if.source out_ch
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;
  logic [7:0] sel_byte;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  assign load   = head_valid && (!out_valid || out_ch.ready);
  assign at_end = (2'(idx + 2'd1) == head.cnt);
  assign pop    = load && at_end;

  always_comb begin
    case (idx)
      2'd0: begin
        sel_byte = head.data[0];
      end
      2'd1: begin
        sel_byte = head.data[1];
      end
      default: begin
        sel_byte = head.data[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      out_last <= head.last && at_end;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.out_last = out_last;

endmodule

@@ sv/url_percent_decoder.sv @@
// URL percent decoder: takes one encoded byte per cycle while the queue has
// room and emits the decoded stream at one byte per cycle while output ready is
// high. Each input byte turns into zero to three output bytes in the front end;
// a queue (four entries by default) holds them and the back end drains one byte
// a cycle into a registered output. Bytes that yield three outputs only follow
// bytes that yielded nothing, so the sustained rate is one input per cycle with
// output ready high; each result is queued, then registered at the output.
// Depends on urlpd_pkg, urlpd_if, urlpd_front, urlpd_queue, urlpd_back.
`include "url_percent_decoder_macros.svh"

module url_percent_decoder import urlpd_pkg::*; #(
  parameter int QueueDepth = URLPD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  urlpd_in_if.sink    in_ch,
  urlpd_out_if.source out_ch
);

  logic          q_ready;
  logic          push;
  entry_t        push_entry;
  logic          pop;
  entry_t        head;
  logic          head_valid;
  front_status_t front_st;

  urlpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry),
    .status     (front_st)
  );

  urlpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  urlpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  `URLPD_ASSERT(a_last_pushes, in_ch.valid && in_ch.ready && in_ch.in_last |-> push, "last byte produced no output")
  `URLPD_ASSERT(a_last_idle, in_ch.valid && in_ch.ready && in_ch.in_last |=> front_st.phase == PH_IDLE, "phase not idle after message end")
  `URLPD_ASSERT_ALWAYS(a_no_empty_push, push |-> push_entry.cnt != 2'd0, "empty entry pushed")

endmodule

@@ bench/urlpd_tb_pkg.sv @@
// Decoded-byte scoreboard for the URL percent decoder bench.
// Depends on urlpd_pkg for the escape phase codes.
package urlpd_tb_pkg;
  import urlpd_pkg::*;

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF  = 8'h66;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_LA) v = c - CH_LA + 8'd10;
    else if (c >= CH_UA) v = c - CH_UA + 8'd10;
    else v = c - CH_0;
    return v[3:0];
  endfunction

  class decode_scoreboard;
    logic [1:0] phase;
    logic [7:0] held_digit;
    decoded_t   decoded_q[$];
    decoded_t   step_q[$];
    int         mismatches;

    function new();
      phase      = PH_IDLE;
      held_digit = 8'h00;
      mismatches = 0;
    endfunction

    function void emit(logic [7:0] b);
      step_q.push_back('{data: b, last: 1'b0});
    endfunction

    // Decode one byte as if no escape were open.
    function void decode_plain(logic [7:0] b);
      if (b == CH_PCT) begin
        phase = PH_PCT;
      end else begin
        phase = PH_IDLE;
        emit(b);
      end
    endfunction

    // Predict the decoded bytes caused by one accepted encoded byte.
    function void note_encoded(logic [7:0] b, logic last);
      step_q = {};
      case (phase)
        PH_PCT: begin
          if (is_hex_char(b)) begin
            held_digit = b;
            phase      = PH_DIGIT;
          end else begin
            emit(CH_PCT);
            decode_plain(b);
          end
        end
        PH_DIGIT: begin
          if (is_hex_char(b)) begin
            emit({hex_nibble(held_digit), hex_nibble(b)});
            phase = PH_IDLE;
          end else begin
            emit(CH_PCT);
            emit(held_digit);
            decode_plain(b);
          end
        end
        default: decode_plain(b);
      endcase
      if (last) begin
        // Flush whatever escape is still open.
        if (phase == PH_PCT) begin
          emit(CH_PCT);
        end else if (phase == PH_DIGIT) begin
          emit(CH_PCT);
          emit(held_digit);
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        phase      = PH_IDLE;
        held_digit = 8'h00;
      end
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    endfunction

    function void check_decoded(logic [7:0] b, logic last);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected output transaction: byte %h last %b", b, last);
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== b || want.last !== last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("output mismatch: byte exp %h got %h, last exp %b got %b",
                   want.data, b, want.last, last);
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

endpackage

@@ bench/tb_url_percent_decoder.sv @@
// Top-level bench for url_percent_decoder: drives encoded messages with bursty
// input and a stalling output, and checks every decoded byte against a predictor.
// Depends on urlpd_pkg, urlpd_if, url_percent_decoder and urlpd_tb_pkg.
module tb_url_percent_decoder import urlpd_pkg::*, urlpd_tb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 425;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;

  urlpd_in_if  in_ch();
  urlpd_out_if out_ch();

  url_percent_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decode_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Observe both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_encoded(in_ch.in_byte, in_ch.in_last);
      if (out_ch.valid && out_ch.ready) sb.check_decoded(out_ch.out_byte, out_ch.out_last);
    end
  end

  // Receiver stall pattern: ready follows one of four randomly chosen modes.
  initial begin
    int mode;
    int cnt;
    mode = 0;
    cnt  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cnt % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 1) == 1);
        2: out_ch.ready = (cnt % 4 == 0);
        default: out_ch.ready = ($urandom_range(0, 9) != 0);
      endcase
      cnt++;
    end
  end

  function automatic logic [7:0] random_hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return CH_0 + k[7:0];
    if (k < 16) return CH_LA + k[7:0] - 8'd10;
    return CH_UA + k[7:0] - 8'd16;
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (is_hex_char(b));
    return b;
  endfunction

  // Present one byte, hold until accepted, then idle between bursts.
  task automatic send_byte(logic [7:0] b, logic last);
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    in_ch.in_last = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic send_message(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_random_message();
    logic [7:0] msg[$];
    int len;
    int kind;
    len = $urandom_range(1, 10);
    for (int k = 0; k < len; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        msg.push_back(CH_PCT);
        msg.push_back(random_hex_char());
        msg.push_back(random_hex_char());
      end else if (kind < 55) begin
        msg.push_back(CH_PCT);
        msg.push_back(random_non_hex());
      end else if (kind < 62) begin
        msg.push_back(CH_PCT);
        msg.push_back(random_hex_char());
        msg.push_back(random_non_hex());
      end else if (kind < 67) begin
        msg.push_back(CH_PCT);
      end else begin
        msg.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h01;
    in_ch.in_last = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    burst_left = $urandom_range(1, 8);

    send_message("%41");
    send_message("%6a%Ff");
    send_message("%g%@1");
    send_message("%4/");
    send_message("%%9:");
    send_message("x%");
    send_message("%0");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);

    // Hold off until every decoded byte of the directed part is out.
    in_ch.valid = 1'b0;
    wait_drained();
    @(negedge clk);

    while (items_sent < ITEM_TARGET) send_random_message();

    in_ch.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
